@@ design/edp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edp_pkg
// Types, constants and helpers shared by the entropy difference pooling block.
// ----------------------------------------------------------------------------
package edp_pkg;

  // fixed point format
  localparam int FRAC_BITS = 16;
  localparam int ENT_W     = 32;
  localparam int VAR_W     = 31;
  localparam int SUM_W     = 48;
  localparam int SCORE_W   = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 32;

  // log2 argument: 4.0 + mixed variance in quarter units, FRAC_BITS+2 fraction bits
  localparam int XW       = VAR_W + 3;
  localparam int MW       = 31;
  localparam int SHIFT_W  = 4;
  localparam int INT_MAX  = XW - 1 - (FRAC_BITS + 2);
  localparam int W_W      = SHIFT_W + FRAC_BITS;
  localparam int PROD_W   = ENT_W + W_W + 1;
  localparam int MAG_W    = PROD_W + 1 - FRAC_BITS;
  localparam int ITER_W   = 6;
  localparam int MODE_W   = 3;

  localparam logic [XW-1:0] X_BASE = XW'(4) << FRAC_BITS;
  localparam logic [CFG_DAT_W-1:0] THR_RESET = 32'd3781759;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WEIGHT_MODE = 1'b0,
    REG_BASE_THR    = 1'b1
  } edp_reg_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_SQR,
    ST_MUL,
    ST_ABS,
    ST_ACC,
    ST_DINIT,
    ST_DIV,
    ST_EMIT
  } edp_state_t;

  typedef struct packed {
    logic load;
    logic norm_step;
    logic sqr_step;
    logic sqr_first;
    logic mul;
    logic absd;
    logic acc;
    logic div_init;
    logic div_step;
    logic emit;
  } edp_cmd_t;

  typedef struct packed {
    logic norm_done;
    logic skip;
    logic last;
    logic out_free;
  } edp_status_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] ar;
    logic [2:0] ad;
  } edp_weights_t;

  // quarter weight of the reference variance in each term
  function automatic edp_weights_t mode_weights(input logic [MODE_W-1:0] mode);
    edp_weights_t w;
    w = '{valid: 1'b1, ar: 3'd4, ad: 3'd0};
    case (mode)
      3'd0: w = '{valid: 1'b1, ar: 3'd4, ad: 3'd0};
      3'd1: w = '{valid: 1'b1, ar: 3'd4, ad: 3'd4};
      3'd2: w = '{valid: 1'b1, ar: 3'd0, ad: 3'd0};
      3'd3: w = '{valid: 1'b1, ar: 3'd2, ad: 3'd2};
      3'd4: w = '{valid: 1'b1, ar: 3'd4, ad: 3'd2};
      3'd5: w = '{valid: 1'b1, ar: 3'd4, ad: 3'd3};
      3'd6: w = '{valid: 1'b1, ar: 3'd4, ad: 3'd1};
      default: w = '{valid: 1'b0, ar: 3'd0, ad: 3'd0};
    endcase
    return w;
  endfunction

  // log argument for quarter weight a of rv and 4-a of dv
  function automatic logic [XW-1:0] log_arg(input logic [VAR_W-1:0] rv,
                                            input logic [VAR_W-1:0] dv,
                                            input logic [2:0] a);
    logic [XW-1:0] pr;
    logic [XW-1:0] pd;
    pr = XW'(rv) * XW'(a);
    pd = XW'(dv) * XW'(3'd4 - a);
    return X_BASE + pr + pd;
  endfunction

endpackage

@@ design/edp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edp interfaces
// Valid/ready channels for block words, score words and register writes.
// ----------------------------------------------------------------------------
interface edp_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [edp_pkg::ENT_W-1:0]    ref_entropy;
  logic        [edp_pkg::VAR_W-1:0]    ref_variance;
  logic signed [edp_pkg::ENT_W-1:0]    dis_entropy;
  logic        [edp_pkg::VAR_W-1:0]    dis_variance;
  logic                                is_last;

  modport source (output valid, ref_entropy, ref_variance, dis_entropy, dis_variance,
                  is_last, input ready);
  modport sink (input valid, ref_entropy, ref_variance, dis_entropy, dis_variance,
                is_last, output ready);
endinterface

interface edp_out_if;
  logic                            valid;
  logic                            ready;
  logic [edp_pkg::SCORE_W-1:0]     mean_score;

  modport source (output valid, mean_score, input ready);
  modport sink (input valid, mean_score, output ready);
endinterface

interface edp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [edp_pkg::CFG_IDX_W-1:0]     index;
  logic [edp_pkg::CFG_DAT_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/entropy_difference_pooling.sv @@
`timescale 1ns / 1ps
// A block word occupies the unit from accept through normalizing (0 to 15 shifts),
// 16 squarings in the two parallel log2 units, then mul, abs, add.
// A skipped block (both entropies under threshold, or mode 7) goes from normalize straight to add.
// A last word then inits and runs the bit-serial divider, then loads the score.
// Throughput: one word at a time; a new score waits to load while the old one is stalled.
// Reset (synchronous, rst_n low): mode 0, threshold 3781759, sum and count cleared.
// ----------------------------------------------------------------------------
// entropy_difference_pooling
// Pools log-variance weighted entropy differences into a mean score per plane.
// ----------------------------------------------------------------------------
module entropy_difference_pooling #(
  parameter int MAX_BLOCKS = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  edp_in_if.sink      in_bus,
  edp_out_if.source   out_bus,
  edp_cfg_if.sink     cfg_bus
);
  import edp_pkg::*;

  edp_cmd_t    cmd;
  edp_status_t status;

  assign cfg_bus.ready = 1'b1;

  edp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_bus.valid), .in_ready(in_bus.ready),
    .status(status), .cmd(cmd)
  );

  edp_datapath #(.MAX_BLOCKS(MAX_BLOCKS)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_ref_entropy(in_bus.ref_entropy), .in_ref_variance(in_bus.ref_variance),
    .in_dis_entropy(in_bus.dis_entropy), .in_dis_variance(in_bus.dis_variance),
    .in_is_last(in_bus.is_last),
    .cfg_we(cfg_bus.valid), .cfg_index(cfg_bus.index), .cfg_data(cfg_bus.data),
    .out_ready(out_bus.ready), .out_valid(out_bus.valid),
    .out_mean_score(out_bus.mean_score),
    .cmd(cmd), .status(status)
  );

endmodule

@@ design/edp_log2.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edp_log2
// Iterative log2: one normalizing shift or one mantissa squaring per cycle.
// ----------------------------------------------------------------------------
module edp_log2 (
  input  logic                   clk,
  input  logic                   load,
  input  logic [edp_pkg::XW-1:0] x_in,
  input  logic                   norm_step,
  input  logic                   sqr_step,
  input  logic                   sqr_first,
  output logic                   norm_done,
  output logic [edp_pkg::W_W-1:0] w
);
  import edp_pkg::*;

  logic [XW-1:0]        x_r, x_nxt;
  logic [SHIFT_W-1:0]   s_r, s_nxt;
  logic [MW-1:0]        m_r, m_nxt;
  logic [FRAC_BITS-1:0] frac_r, frac_nxt;
  logic [MW-1:0]        m_src;
  logic [2*MW-1:0]      sq;
  logic [MW:0]          t;

  assign norm_done = x_r[XW-1];
  assign m_src     = sqr_first ? x_r[XW-1 -: MW] : m_r;
  assign sq        = (2*MW)'(m_src) * (2*MW)'(m_src);
  assign t         = sq[2*MW-1 -: MW+1];
  assign w         = {SHIFT_W'(INT_MAX) - s_r, frac_r};

  // shift to top bit, then square once per fraction bit
  always_comb begin
    x_nxt    = x_r;
    s_nxt    = s_r;
    m_nxt    = m_r;
    frac_nxt = frac_r;
    if (load) begin
      x_nxt = x_in;
      s_nxt = '0;
    end else if (norm_step && !x_r[XW-1]) begin
      x_nxt = {x_r[XW-2:0], 1'b0};
      s_nxt = s_r + 1'b1;
    end
    if (sqr_step) begin
      if (t[MW]) begin
        m_nxt    = t[MW:1];
        frac_nxt = {frac_r[FRAC_BITS-2:0], 1'b1};
      end else begin
        m_nxt    = t[MW-1:0];
        frac_nxt = {frac_r[FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    s_r    <= s_nxt;
    m_r    <= m_nxt;
    frac_r <= frac_nxt;
  end

endmodule

@@ design/edp_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edp_datapath
// Registers, log units, multipliers, accumulator, divider and score register.
// ----------------------------------------------------------------------------
module edp_datapath #(
  parameter int MAX_BLOCKS = 65536
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [edp_pkg::ENT_W-1:0]  in_ref_entropy,
  input  logic        [edp_pkg::VAR_W-1:0]  in_ref_variance,
  input  logic signed [edp_pkg::ENT_W-1:0]  in_dis_entropy,
  input  logic        [edp_pkg::VAR_W-1:0]  in_dis_variance,
  input  logic                              in_is_last,
  input  logic                              cfg_we,
  input  logic [edp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [edp_pkg::CFG_DAT_W-1:0]     cfg_data,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [edp_pkg::SCORE_W-1:0]       out_mean_score,
  input  edp_pkg::edp_cmd_t                 cmd,
  output edp_pkg::edp_status_t              status
);
  import edp_pkg::*;

  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  logic [MODE_W-1:0]        mode_r;
  logic signed [ENT_W-1:0]  thr_r;
  logic signed [ENT_W-1:0]  re_r, de_r;
  logic                     skip_r, last_r;
  logic signed [PROD_W-1:0] pr_r, pd_r;
  logic [MAG_W-1:0]         mag_r;
  logic [SUM_W-1:0]         sum_r, sum_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [SUM_W-1:0]         quo_r;
  logic [CNT_W-1:0]         rem_r;
  logic                     quo_ov;
  logic [SCORE_W-1:0]       score_r;

  edp_weights_t             wts;
  logic [XW-1:0]            x_ref, x_dis;
  logic                     nd_ref, nd_dis;
  logic [W_W-1:0]           w_ref, w_dis;
  logic signed [PROD_W:0]   diff;
  logic [PROD_W:0]          diff_abs;
  logic [SUM_W:0]           sum_add;
  logic [CNT_W:0]           trial;
  logic                     trial_ge;

  assign wts   = mode_weights(mode_r);
  assign x_ref = log_arg(in_ref_variance, in_dis_variance, wts.ar);
  assign x_dis = log_arg(in_ref_variance, in_dis_variance, wts.ad);

  edp_log2 u_log_ref (
    .clk(clk), .load(cmd.load), .x_in(x_ref), .norm_step(cmd.norm_step),
    .sqr_step(cmd.sqr_step), .sqr_first(cmd.sqr_first), .norm_done(nd_ref), .w(w_ref)
  );

  edp_log2 u_log_dis (
    .clk(clk), .load(cmd.load), .x_in(x_dis), .norm_step(cmd.norm_step),
    .sqr_step(cmd.sqr_step), .sqr_first(cmd.sqr_first), .norm_done(nd_dis), .w(w_dis)
  );

  assign status.norm_done = nd_ref && nd_dis;
  assign status.skip      = skip_r;
  assign status.last      = last_r;
  assign status.out_free  = !out_valid || out_ready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
      thr_r  <= THR_RESET;
    end else if (cfg_we) begin
      case (edp_reg_t'(cfg_index))
        REG_WEIGHT_MODE: mode_r <= cfg_data[MODE_W-1:0];
        REG_BASE_THR:    thr_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture block word, decide whether it adds to the sum
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      re_r   <= in_ref_entropy;
      de_r   <= in_dis_entropy;
      last_r <= in_is_last;
      skip_r <= (in_ref_entropy < thr_r && in_dis_entropy < thr_r) || !wts.valid;
    end
  end

  // weighted products, then absolute difference
  assign diff     = (PROD_W+1)'(pr_r) - (PROD_W+1)'(pd_r);
  assign diff_abs = diff[PROD_W] ? (PROD_W+1)'(-diff) : (PROD_W+1)'(diff);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      pr_r <= PROD_W'(re_r) * signed'({1'b0, w_ref});
      pd_r <= PROD_W'(de_r) * signed'({1'b0, w_dis});
    end
    if (cmd.absd) begin
      mag_r <= diff_abs[PROD_W:FRAC_BITS];
    end
  end

  // saturating sum and count
  assign sum_add = (SUM_W+1)'(sum_r) + (SUM_W+1)'(mag_r);

  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (cmd.acc) begin
      if (!skip_r) begin
        sum_nxt = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
      end
      if (cnt_r < CNT_W'(MAX_BLOCKS)) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
    if (cmd.emit) begin
      sum_nxt = '0;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign trial    = {rem_r, quo_r[SUM_W-1]};
  assign trial_ge = trial >= (CNT_W+1)'(cnt_r);

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo_r <= sum_r;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[SUM_W-2:0], trial_ge};
      rem_r <= trial_ge ? CNT_W'(trial - (CNT_W+1)'(cnt_r)) : trial[CNT_W-1:0];
    end
  end

  assign quo_ov = |quo_r[SUM_W-1:SCORE_W];

  // score register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      score_r <= quo_ov ? '1 : quo_r[SCORE_W-1:0];
    end
  end

  assign out_mean_score = score_r;

endmodule

@@ design/edp_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edp_ctrl
// Sequencer for normalize, square, multiply, accumulate and divide steps.
// ----------------------------------------------------------------------------
module edp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  edp_pkg::edp_status_t  status,
  output edp_pkg::edp_cmd_t     cmd
);
  import edp_pkg::*;

  edp_state_t         state_r, state_nxt;
  logic [ITER_W-1:0]  iter_r, iter_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        iter_nxt = '0;
        if (status.skip) begin
          state_nxt = ST_ACC;
        end else if (status.norm_done) begin
          state_nxt = ST_SQR;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      ST_SQR: begin
        cmd.sqr_step  = 1'b1;
        cmd.sqr_first = (iter_r == '0);
        iter_nxt      = iter_r + 1'b1;
        if (iter_r == ITER_W'(FRAC_BITS - 1)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_ABS;
      end
      ST_ABS: begin
        cmd.absd  = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = status.last ? ST_DINIT : ST_IDLE;
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        iter_nxt     = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        iter_nxt     = iter_r + 1'b1;
        if (iter_r == ITER_W'(SUM_W - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ design/edp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edp_checker
// Port-level checks on the pooling block, bound to its top level.
// ----------------------------------------------------------------------------
module edp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [edp_pkg::SCORE_W-1:0]   out_mean_score,
  input logic                          cfg_ready
);
  import edp_pkg::*;

  // stalled score holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mean_score))
    else $error("score dropped or changed while stalled");

  // one word at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted while busy");

  // ready for words once out of reset
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("not ready after reset");

  // register port never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("register port stalled");

endmodule

bind entropy_difference_pooling edp_checker u_edp_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_bus.valid), .in_ready(in_bus.ready),
  .out_valid(out_bus.valid), .out_ready(out_bus.ready),
  .out_mean_score(out_bus.mean_score), .cfg_ready(cfg_bus.ready)
);
